@@ src/octree_cell_locator_assert.svh @@
// Assertion macros shared by the octree cell locator RTL.
`ifndef OCTREE_CELL_LOCATOR_ASSERT_SVH
`define OCTREE_CELL_LOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCTCL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OCTCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/octcl_pkg.sv @@
// Package with shared types and constants of the octree cell locator.
`default_nettype none
package octcl_pkg;

    localparam int DEF_MAX_LEVELS  = 5;
    localparam int DEF_COORD_WIDTH = 24;

    localparam int LEVEL_W     = 3;
    localparam int PATH_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_LEVELS_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_X      = 3'd0,
        CFG_ROOT_Y      = 3'd1,
        CFG_ROOT_Z      = 3'd2,
        CFG_HALF_WIDTH  = 3'd3,
        CFG_LEVELS      = 3'd4
    } t_cfg_idx;

    // Control bits that travel with each item along the cell chain.
    typedef struct packed {
        logic valid;
        logic done;
        logic straddled;
    } t_ctl;

endpackage
`default_nettype wire

@@ src/octcl_cell.sv @@
// One level of the octree descent: straddle test and child selection, registered.
`default_nettype none
module octcl_cell #(
    parameter int COORD_WIDTH = octcl_pkg::DEF_COORD_WIDTH,
    parameter int MAX_LEVELS  = octcl_pkg::DEF_MAX_LEVELS,
    parameter int NW          = COORD_WIDTH + 2,
    parameter int DW          = $clog2(MAX_LEVELS + 1),
    parameter int PW          = 3 * MAX_LEVELS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  octcl_pkg::t_ctl                       i_ctl,
    input  wire [2:0][COORD_WIDTH-1:0]            i_sph,
    input  wire [COORD_WIDTH-2:0]                 i_rad,
    input  wire [2:0][NW-1:0]                     i_node,
    input  wire [COORD_WIDTH-2:0]                 i_hw,
    input  wire [octcl_pkg::CFG_LEVELS_W-1:0]     i_limit,
    input  wire [DW-1:0]                          i_depth,
    input  wire [PW-1:0]                          i_path,
    output octcl_pkg::t_ctl                       o_ctl,
    output logic [2:0][COORD_WIDTH-1:0]           o_sph,
    output logic [COORD_WIDTH-2:0]                o_rad,
    output logic [2:0][NW-1:0]                    o_node,
    output logic [COORD_WIDTH-2:0]                o_hw,
    output logic [octcl_pkg::CFG_LEVELS_W-1:0]    o_limit,
    output logic [DW-1:0]                         o_depth,
    output logic [PW-1:0]                         o_path
);
    import octcl_pkg::*;

    localparam int EXT_W = NW - (COORD_WIDTH - 1);

    t_ctl                  r_ctl, n_ctl;
    logic [2:0][COORD_WIDTH-1:0] r_sph;
    logic [COORD_WIDTH-2:0] r_rad;
    logic [2:0][NW-1:0]    r_node, n_node;
    logic [COORD_WIDTH-2:0] r_hw, n_hw;
    logic [CFG_LEVELS_W-1:0] r_limit;
    logic [DW-1:0]         r_depth, n_depth;
    logic [PW-1:0]         r_path, n_path;

    logic signed [NW-1:0]  w_s   [3];
    logic signed [NW-1:0]  w_lo  [3];
    logic signed [NW-1:0]  w_hi  [3];
    logic [2:0]            w_lt;
    logic [2:0]            w_st;
    logic [COORD_WIDTH-2:0] w_step;
    logic [NW-1:0]         w_step_e;
    logic [NW-1:0]         w_rad_e;

    always_comb begin
        w_rad_e  = {{EXT_W{1'b0}}, i_rad};
        w_step   = i_hw >> 1;
        w_step_e = {{EXT_W{1'b0}}, w_step};
        for (int a = 0; a < 3; a++) begin
            w_s[a]  = $signed({{2{i_sph[a][COORD_WIDTH-1]}}, i_sph[a]});
            w_lo[a] = w_s[a] - $signed(w_rad_e);
            w_hi[a] = w_s[a] + $signed(w_rad_e);
            w_lt[a] = $signed(i_node[a]) < w_s[a];
            w_st[a] = w_lt[a] ? ($signed(i_node[a]) > w_lo[a])
                              : ($signed(i_node[a]) < w_hi[a]);
        end
    end

    // Once an axis straddles the remaining axes do not matter, so any set bit stops here.
    always_comb begin
        n_ctl   = i_ctl;
        n_node  = i_node;
        n_hw    = i_hw;
        n_depth = i_depth;
        n_path  = i_path;
        if (i_ctl.valid && !i_ctl.done) begin
            if (|w_st) begin
                n_ctl.done      = 1'b1;
                n_ctl.straddled = 1'b1;
            end else if (int'(i_depth) >= int'(i_limit)) begin
                n_ctl.done = 1'b1;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    n_node[a] = w_lt[a] ? (i_node[a] + w_step_e) : (i_node[a] - w_step_e);
                end
                n_hw    = w_step;
                n_depth = i_depth + DW'(1);
                n_path  = PW'({i_path, w_lt[2], w_lt[1], w_lt[0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sph   <= i_sph;
            r_rad   <= i_rad;
            r_node  <= n_node;
            r_hw    <= n_hw;
            r_limit <= i_limit;
            r_depth <= n_depth;
            r_path  <= n_path;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_sph   = r_sph;
    assign o_rad   = r_rad;
    assign o_node  = r_node;
    assign o_hw    = r_hw;
    assign o_limit = r_limit;
    assign o_depth = r_depth;
    assign o_path  = r_path;

endmodule
`default_nettype wire

@@ src/octree_cell_locator.sv @@
// Top level of the octree cell locator: configuration registers and the chain of level cells.
//
//  Channel   Direction  Handshake                     Payload
//  in        input      i_in_valid / o_in_ready       i_center_x/y/z, i_radius
//  out       output     o_out_valid / i_out_ready     o_level, o_node_path, o_straddled
//  cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Each sphere passes through MAX_LEVELS+1 cells, one octree level per cell.
// Spheres enter back to back, one per cycle, while the output side takes results.
// The whole chain moves with a single enable; a result not taken stalls every cell and
// holds o_in_ready low until the output transaction completes.
// Reset is synchronous and active low; it clears the configuration and the cell valid bits.
// Configuration writes are always taken and must only happen while the chain is empty.
`default_nettype none
module octree_cell_locator #(
    parameter int MAX_LEVELS  = octcl_pkg::DEF_MAX_LEVELS,
    parameter int COORD_WIDTH = octcl_pkg::DEF_COORD_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire signed [COORD_WIDTH-1:0]        i_center_x,
    input  wire signed [COORD_WIDTH-1:0]        i_center_y,
    input  wire signed [COORD_WIDTH-1:0]        i_center_z,
    input  wire [COORD_WIDTH-2:0]               i_radius,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [octcl_pkg::LEVEL_W-1:0]       o_level,
    output logic [octcl_pkg::PATH_W-1:0]        o_node_path,
    output logic                                o_straddled,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [octcl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [COORD_WIDTH-1:0]               i_cfg_data
);
    import octcl_pkg::*;

    `include "octree_cell_locator_assert.svh"

    // Node centers carry two extra bits so that center plus or minus radius never wraps.
    localparam int NW = COORD_WIDTH + 2;
    localparam int DW = $clog2(MAX_LEVELS + 1);
    localparam int PW = 3 * MAX_LEVELS;
    localparam int NS = MAX_LEVELS + 1;

    logic [COORD_WIDTH-1:0]  r_root_x, r_root_y, r_root_z;
    logic [COORD_WIDTH-2:0]  r_root_hw;
    logic [CFG_LEVELS_W-1:0] r_levels;

    logic                         w_en;
    t_ctl                         s_ctl   [0:NS];
    logic [2:0][COORD_WIDTH-1:0]  s_sph   [0:NS];
    logic [COORD_WIDTH-2:0]       s_rad   [0:NS];
    logic [2:0][NW-1:0]           s_node  [0:NS];
    logic [COORD_WIDTH-2:0]       s_hw    [0:NS];
    logic [CFG_LEVELS_W-1:0]      s_limit [0:NS];
    logic [DW-1:0]                s_depth [0:NS];
    logic [PW-1:0]                s_path  [0:NS];

    // Configuration registers; indexes past the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x  <= '0;
            r_root_y  <= '0;
            r_root_z  <= '0;
            r_root_hw <= '0;
            r_levels  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROOT_X:     r_root_x  <= i_cfg_data;
                CFG_ROOT_Y:     r_root_y  <= i_cfg_data;
                CFG_ROOT_Z:     r_root_z  <= i_cfg_data;
                CFG_HALF_WIDTH: r_root_hw <= i_cfg_data[COORD_WIDTH-2:0];
                CFG_LEVELS:     r_levels  <= i_cfg_data[CFG_LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    // The chain advances whenever the last cell is empty or its result is being taken.
    assign w_en       = !s_ctl[NS].valid || i_out_ready;
    assign o_in_ready = w_en;

    // Entry of the chain: the new sphere starts at the root node.
    always_comb begin
        s_ctl[0].valid     = i_in_valid;
        s_ctl[0].done      = 1'b0;
        s_ctl[0].straddled = 1'b0;
        s_sph[0][0]  = i_center_x;
        s_sph[0][1]  = i_center_y;
        s_sph[0][2]  = i_center_z;
        s_rad[0]     = i_radius;
        s_node[0][0] = {{2{r_root_x[COORD_WIDTH-1]}}, r_root_x};
        s_node[0][1] = {{2{r_root_y[COORD_WIDTH-1]}}, r_root_y};
        s_node[0][2] = {{2{r_root_z[COORD_WIDTH-1]}}, r_root_z};
        s_hw[0]      = r_root_hw;
        s_limit[0]   = (int'(r_levels) > MAX_LEVELS) ? CFG_LEVELS_W'(MAX_LEVELS) : r_levels;
        s_depth[0]   = '0;
        s_path[0]    = '0;
    end

    // Cell g tests the node at depth g; the last cell only tests, it never descends.
    for (genvar g = 0; g < NS; g++) begin : g_cell
        octcl_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .MAX_LEVELS  (MAX_LEVELS),
            .NW          (NW),
            .DW          (DW),
            .PW          (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (s_ctl[g]),
            .i_sph   (s_sph[g]),
            .i_rad   (s_rad[g]),
            .i_node  (s_node[g]),
            .i_hw    (s_hw[g]),
            .i_limit (s_limit[g]),
            .i_depth (s_depth[g]),
            .i_path  (s_path[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_sph   (s_sph[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_node  (s_node[g+1]),
            .o_hw    (s_hw[g+1]),
            .o_limit (s_limit[g+1]),
            .o_depth (s_depth[g+1]),
            .o_path  (s_path[g+1])
        );
    end

    // The last cell's register is the output register.
    assign o_out_valid = s_ctl[NS].valid;
    assign o_level     = LEVEL_W'(s_depth[NS]);
    assign o_node_path = PATH_W'(s_path[NS]);
    assign o_straddled = s_ctl[NS].straddled;

    `OCTCL_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, !o_in_ready,
        "input taken while a result is stalled")
    `OCTCL_ASSERT_NEXT(a_accept_enters_chain, i_clk, i_rst_n,
        i_in_valid && o_in_ready, s_ctl[1].valid,
        "accepted sphere did not enter the first cell")
    `OCTCL_ASSERT_SAME(a_result_finished, i_clk, i_rst_n,
        o_out_valid, s_ctl[NS].done,
        "result leaves the chain before its descent ended")
    `OCTCL_ASSERT_SAME(a_root_has_empty_path, i_clk, i_rst_n,
        o_out_valid && (s_depth[NS] == '0), s_path[NS] == '0,
        "root level result carries a nonzero path")

endmodule
`default_nettype wire

@@ tb/octree_cell_locator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the octree cell locator with directed and random spheres.
module octree_cell_locator_tb;
    import octcl_pkg::*;

    localparam int CW          = DEF_COORD_WIDTH;
    // One cell per level plus the root cell gives the chain depth.
    localparam int LATENCY     = DEF_MAX_LEVELS + 1;
    // No legal run goes this long without a single transaction on any channel.
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 144;
    // Register indexes past the last real register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam logic signed [CW-1:0] COORD_MIN  = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX  = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-2:0]        RADIUS_MAX = '1;
    localparam int                   HALF_ROOT  = 32'h0001_0000;

    // What the block reports for one sphere: depth, octant digits and why it stopped.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PATH_W-1:0]  path;
        logic               straddled;
    } t_cell_result;

    // Mirrors the configuration registers, predicts the storing node of every sphere
    // that enters the block, and compares the results in order of arrival.
    class t_cell_expectations;
        t_cell_result expected_cells[$];
        longint      root_c[3];
        longint      half_w;
        int unsigned depth_cap;
        int          errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
            case (idx)
                CFG_ROOT_X:     root_c[0] = longint'(signed'(data));
                CFG_ROOT_Y:     root_c[1] = longint'(signed'(data));
                CFG_ROOT_Z:     root_c[2] = longint'(signed'(data));
                CFG_HALF_WIDTH: half_w = longint'(data[CW-2:0]);
                CFG_LEVELS:     depth_cap = 32'(data[CFG_LEVELS_W-1:0]);
                default: ;
            endcase
        endfunction

        // Descends from the root until the sphere crosses a center plane or no
        // deeper level exists. Node centers are kept at full 64-bit precision.
        function t_cell_result locate_cell(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                           logic signed [CW-1:0] z, logic [CW-2:0] r);
            longint      sph[3];
            longint      node[3];
            longint      rad;
            longint      hw;
            longint      step;
            longint      path;
            int unsigned limit;
            int unsigned depth;
            logic [2:0]  oct;
            bit          strad;
            bit          done;
            int          a;
            t_cell_result res;

            sph[0] = longint'(x);
            sph[1] = longint'(y);
            sph[2] = longint'(z);
            rad    = longint'(r);
            node   = root_c;
            hw     = half_w;
            limit  = (depth_cap > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : depth_cap;
            depth  = 0;
            path   = 0;
            strad  = 1'b0;
            done   = 1'b0;
            while (!done) begin
                oct = '0;
                for (a = 0; a < 3 && !strad; a++) begin
                    if (node[a] < sph[a]) begin
                        if (node[a] > sph[a] - rad) strad = 1'b1;
                        else oct[a] = 1'b1;
                    end else if (node[a] < sph[a] + rad) begin
                        strad = 1'b1;
                    end
                end
                // Octant bits already set at a straddling node are dropped.
                if (strad || depth >= limit) begin
                    done = 1'b1;
                end else begin
                    step = hw >> 1;
                    for (a = 0; a < 3; a++)
                        node[a] = oct[a] ? node[a] + step : node[a] - step;
                    hw    = step;
                    path  = (path << 3) | longint'(oct);
                    depth = depth + 1;
                end
            end
            res.level     = depth[LEVEL_W-1:0];
            res.path      = path[PATH_W-1:0];
            res.straddled = strad;
            return res;
        endfunction

        function void note_sphere(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic signed [CW-1:0] z, logic [CW-2:0] r);
            expected_cells = {expected_cells, locate_cell(x, y, z, r)};
        endfunction

        task report(string msg);
            $display("%0t: MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_cell(t_cell_result got);
            t_cell_result want;
            if (expected_cells.size() == 0) begin
                report($sformatf("result with nothing pending: level %0d path %05o",
                                 got.level, got.path));
                return;
            end
            want = expected_cells.pop_front();
            if (got.level != want.level)
                report($sformatf("level %0d, expected %0d", got.level, want.level));
            if (got.path != want.path)
                report($sformatf("node_path %05o, expected %05o", got.path, want.path));
            if (got.straddled != want.straddled)
                report($sformatf("straddled %0b, expected %0b",
                                 got.straddled, want.straddled));
        endtask

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [CW-1:0]   i_center_x;
    logic signed [CW-1:0]   i_center_y;
    logic signed [CW-1:0]   i_center_z;
    logic [CW-2:0]          i_radius;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [LEVEL_W-1:0]     o_level;
    logic [PATH_W-1:0]      o_node_path;
    logic                   o_straddled;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CW-1:0]          i_cfg_data;

    t_cell_expectations sb;
    // Idle switches for each side, changed per phase so some phases run with no gaps.
    bit     in_idle;
    bit     out_idle;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit     hold_outputs;
    int     quiet_cycles;
    // The root cube as last written, used to aim random spheres into the tree.
    longint root_now[3];
    longint hw_now;

    octree_cell_locator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_radius    (i_radius),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level),
        .o_node_path (o_node_path),
        .o_straddled (o_straddled),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: every transaction is seen here at the clock edge that completes it.
    // Configuration writes update the mirrored registers, accepted spheres get their
    // prediction queued, and results are checked against the oldest prediction.
    // The watchdog ends the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_sphere(i_center_x, i_center_y, i_center_z, i_radius);
            if (o_out_valid && i_out_ready)
                sb.check_cell(t_cell_result'({o_level, o_node_path, o_straddled}));
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("octree_cell_locator test failed");
                $finish;
            end
        end
    end

    // Receiver: before each result it waits, when out_idle is set, a random number of cycles with ready low,
    // or a long stretch when asked, then keeps ready high until the transaction.
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = out_idle ? $urandom_range(0, 10) : 0;
            if (hold_outputs) begin
                gap          = LONG_HOLD;
                hold_outputs = 1'b0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Offers one sphere after an optional gap and returns at the edge that takes it.
    // Valid is left high so a following sphere with no gap goes out back to back.
    task automatic send_sphere(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z, input logic [CW-2:0] r);
        int gap;
        gap = in_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_center_x <= x;
        i_center_y <= y;
        i_center_z <= z;
        i_radius   <= r;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // Stops offering spheres and waits until every predicted result has come back,
    // then lets the chain run empty for its full depth.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    // Writes all five registers, and optionally one unused index that must change nothing.
    // Only called while the chain is empty.
    task automatic load_config(input logic [CW-1:0] rx, input logic [CW-1:0] ry,
                               input logic [CW-1:0] rz, input logic [CW-1:0] hw_data,
                               input logic [CW-1:0] lv_data, input bit with_spare);
        write_reg(CFG_ROOT_X, rx);
        write_reg(CFG_ROOT_Y, ry);
        write_reg(CFG_ROOT_Z, rz);
        write_reg(CFG_HALF_WIDTH, hw_data);
        write_reg(CFG_LEVELS, lv_data);
        if (with_spare)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      CW'($urandom));
        i_cfg_valid <= 1'b0;
        root_now[0] = longint'(signed'(rx));
        root_now[1] = longint'(signed'(ry));
        root_now[2] = longint'(signed'(rz));
        hw_now      = longint'(hw_data[CW-2:0]);
        @(posedge i_clk);
    endtask

    // A coordinate in or near the root cube on one axis, sometimes on a grid of node
    // centers so that spheres land on or near the dividing planes.
    function automatic logic signed [CW-1:0] near_axis(input longint centre);
        longint off;
        if ($urandom_range(0, 3) == 0)
            off = (hw_now >> $urandom_range(1, DEF_MAX_LEVELS)) *
                  (longint'($urandom_range(0, 6)) - 3);
        else
            off = longint'($urandom_range(0, 32'(2 * hw_now))) - hw_now;
        return CW'(centre + off);
    endfunction

    // Random configuration for one phase; the first phases pin set values, among them the extremes.
    task automatic random_config(input int phase);
        logic [CW-1:0] root_d[3];
        logic [CW-1:0] hw_data;
        logic [CW-1:0] lv_data;
        int            k;
        int            a;
        for (a = 0; a < 3; a++) begin
            if ($urandom_range(0, 3) == 0)
                root_d[a] = CW'($urandom);
            else
                root_d[a] = CW'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
        end
        k       = $urandom_range(4, CW - 2);
        hw_data = CW'((longint'(1) << k) | longint'($urandom_range(0, (1 << k) - 1)));
        if ($urandom_range(0, 4) == 0)
            hw_data = CW'($urandom);
        lv_data = CW'(($urandom_range(0, 1) == 0) ? DEF_MAX_LEVELS : $urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            lv_data = CW'($urandom);
        case (phase)
            0: begin
                root_d  = '{default: '0};
                hw_data = 24'h10_0000;
                lv_data = CW'(DEF_MAX_LEVELS);
            end
            1: begin
                hw_data = '1;
                lv_data = 24'd7;
            end
            2: hw_data = '0;
            default: ;
        endcase
        load_config(root_d[0], root_d[1], root_d[2], hw_data, lv_data, phase[0]);
    endtask

    // Mostly spheres aimed into the root cube with radii small enough to go deep,
    // some with large radii, and some that are pure noise over every bit.
    task automatic random_sphere();
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [CW-2:0]        r;
        int                   kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            x = CW'($urandom);
            y = CW'($urandom);
            z = CW'($urandom);
            r = (CW - 1)'($urandom);
        end else begin
            x = near_axis(root_now[0]);
            y = near_axis(root_now[1]);
            z = near_axis(root_now[2]);
            if (kind == 1)
                r = (CW - 1)'($urandom);
            else if (kind == 2)
                r = '0;
            else
                r = (CW - 1)'($urandom_range(0, 32'(hw_now >> $urandom_range(1, 8))));
        end
        send_sphere(x, y, z, r);
    endtask

    initial begin
        int phase;
        int n;
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_center_x   = '0;
        i_center_y   = '0;
        i_center_z   = '0;
        i_radius     = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ROOT_X;
        i_cfg_data   = '0;
        in_idle      = 1'b0;
        out_idle     = 1'b1;
        hold_outputs = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Root at the origin, half width 65536, all five levels present.
        load_config('0, '0, '0, CW'(HALF_ROOT), CW'(DEF_MAX_LEVELS), 1'b0);
        // Points at and next to the root center with zero radius: no plane is crossed.
        send_sphere(0, 0, 0, 0);
        send_sphere(1, 1, 1, 0);
        send_sphere(-1, -1, -1, 0);
        // Coordinate and radius extremes.
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        send_sphere(COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
        send_sphere(COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX);
        // Straddling on x, on y after x has set its bit, and on z.
        send_sphere(10, 1000, 1000, 20);
        send_sphere(1000, 10, 1000, 20);
        send_sphere(-1000, -1000, 10, 20);
        // A sphere that just touches a plane does not straddle; one more unit does.
        send_sphere(100, 100, 100, 100);
        send_sphere(100, -5000, -5000, 101);
        send_sphere(-100, -100, -100, 100);
        send_sphere(-100, 5000, 5000, 101);
        // Small spheres that cross a first level plane, one on z and one on x.
        send_sphere(CW'(HALF_ROOT / 2 + 5), CW'(-HALF_ROOT / 2 - 5), CW'(HALF_ROOT / 2), 3);
        send_sphere(CW'(HALF_ROOT / 2 + 3), CW'(HALF_ROOT / 2 + 100),
                    CW'(HALF_ROOT / 2 + 100), 4);
        wait_drained();

        // Root at the corners of the range, largest half width, and a level count
        // above the maximum that the block must cap.
        load_config(COORD_MAX, COORD_MIN, COORD_MAX, '1, '1, 1'b1);
        send_sphere(0, 0, 0, 0);
        send_sphere(COORD_MIN, COORD_MAX, COORD_MIN, 0);
        send_sphere(COORD_MAX, COORD_MIN, COORD_MAX, 0);
        send_sphere(12345, -12345, 777, 1000);
        wait_drained();

        // No levels below the root: only the root can be reported.
        load_config(COORD_MIN, COORD_MAX, '0, '0, '0, 1'b0);
        send_sphere(COORD_MIN, COORD_MAX, 0, 0);
        send_sphere(0, 0, 0, RADIUS_MAX);
        wait_drained();

        // Zero half width: every child shares the root center.
        load_config('0, '0, '0, '0, CW'(DEF_MAX_LEVELS), 1'b0);
        send_sphere(0, 0, 0, 0);
        send_sphere(5, 5, 5, 0);
        send_sphere(5, 5, 5, 5);
        wait_drained();

        // Random phases. Idling alternates between both sides, neither, and each
        // side alone. One phase holds the receiver off while spheres keep coming so
        // the chain fills and stalls the input; another stops the sender midway
        // until every result is back.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            in_idle  = (phase % 4 == 0) || (phase % 4 == 2);
            out_idle = (phase % 4 == 0) || (phase % 4 == 3);
            random_config(phase);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == 40)
                    hold_outputs = 1'b1;
                if (phase == 6 && n == 70)
                    wait_drained();
                random_sphere();
            end
            wait_drained();
        end

        if (sb.errors == 0)
            $display("octree_cell_locator test passed");
        else
            $display("octree_cell_locator test failed");
        $finish;
    end

endmodule
